// File: rtl/grmc_pkg.sv
// shared types, constants and the month table of the GPS resync millisecond clock
package grmc_pkg;

	// item kinds carried in the slave tuser
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_FIX  = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SYNC_ENABLE   = 2'd0;
	localparam logic [1:0] REG_ZONE_HOURS    = 2'd1;
	localparam logic [1:0] REG_RESYNC_THRESH = 2'd2;

	// configuration reset values
	localparam logic        SYNC_ENABLE_RST   = 1'b1;
	localparam logic [4:0]  ZONE_HOURS_RST    = 5'd0;
	localparam logic [15:0] RESYNC_THRESH_RST = 16'd2;

	// time constants
	localparam logic [9:0]  MS_PER_SEC     = 10'd1000;
	localparam logic [9:0]  MS_MAX         = 10'd999;
	localparam logic [16:0] MS_PER_CENTI   = 17'd10;
	localparam logic [16:0] DAYS_PER_YEAR  = 17'd365;
	localparam logic [33:0] SEC_PER_DAY    = 34'd86400;
	localparam logic [31:0] SEC_PER_HOUR   = 32'd3600;
	localparam logic [31:0] SEC_PER_MIN    = 32'd60;
	localparam logic [11:0] YEAR_BASE      = 12'd2000;
	// epoch of 2000-01-01 less one day, since the day count is kept one high
	localparam logic [31:0] EPOCH_LESS_DAY = 32'd946598400;
	// reciprocal of 1000 scaled by 2^20, rounded down
	localparam logic [26:0] RECIP_MS       = 27'd1048;
	localparam int          RECIP_SHIFT    = 20;

	// one accepted input beat
	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] fix_year;
		logic [3:0]  fix_month;
		logic [4:0]  fix_day;
		logic [4:0]  fix_hour;
		logic [5:0]  fix_minute;
		logic [5:0]  fix_second;
		logic [6:0]  fix_centi;
		logic [15:0] fix_age_ms;
	} fix_item_t;

	// converted GPS time handed to the state stage
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] gps_sec;
		logic [9:0]  gps_ms;
	} fix_time_t;

	// days before the first of month m in a common year, m already clamped to 1..12
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/grmc_fix_pipe.sv
// input register and calendar conversion pipeline turning a GPS fix into Unix seconds and ms
module grmc_fix_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  grmc_pkg::fix_item_t in_item,
	input  logic [4:0]          zone_hours,
	output logic                out_valid,
	input  logic                out_ready,
	output grmc_pkg::fix_time_t out_time
);

	// stage valids and payloads
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	grmc_pkg::fix_item_t item_s1;

	logic [1:0]  mode_s2;
	logic [16:0] days_p1_s2;
	logic [4:0]  hour_s2;
	logic [5:0]  minute_s2;
	logic [5:0]  second_s2;
	logic [16:0] total_ms_s2;

	logic [1:0]  mode_s3;
	logic [31:0] base_sec_s3;
	logic [6:0]  q_est_s3;
	logic [16:0] total_ms_s3;

	grmc_pkg::fix_time_t time_s4;

	// stage 1 to 2: day count and total milliseconds
	logic [11:0] yr_off;
	logic [7:0]  yr8;
	logic [3:0]  mon_c;
	logic [8:0]  cum_days;
	logic        leap_add;
	logic [8:0]  yr_p3;
	logic [16:0] days_p1;
	logic [16:0] total_ms;

	// stage 2 to 3: base seconds and quotient estimate
	logic signed [16:0] zone_sec;
	logic [31:0]        zone_ext;
	logic [33:0]        day_prod;
	logic [31:0]        base_sec;
	logic [26:0]        recip_prod;

	// stage 3 to 4: quotient correction
	logic [16:0] qk;
	logic [10:0] rem_est;
	logic [6:0]  q_fix;
	logic [9:0]  ms_fix;

	// ready chain, bubbles are squeezed out
	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		yr_off   = (item_s1.fix_year >= grmc_pkg::YEAR_BASE) ?
			(item_s1.fix_year - grmc_pkg::YEAR_BASE) : item_s1.fix_year;
		yr8      = yr_off[7:0];
		if (item_s1.fix_month == 4'd0) begin
			mon_c = 4'd1;
		end else if (item_s1.fix_month > 4'd12) begin
			mon_c = 4'd12;
		end else begin
			mon_c = item_s1.fix_month;
		end
		cum_days = grmc_pkg::days_before_month(mon_c);
		leap_add = (mon_c > 4'd2) && (yr8[1:0] == 2'd0);
		yr_p3    = {1'b0, yr8} + 9'd3;
		days_p1  = 17'(item_s1.fix_day) + 17'(cum_days) + 17'(leap_add)
			+ 17'(yr8) * grmc_pkg::DAYS_PER_YEAR + 17'(yr_p3[8:2]);
		total_ms = 17'(item_s1.fix_centi) * grmc_pkg::MS_PER_CENTI
			+ 17'(item_s1.fix_age_ms);
	end

	always_comb begin
		zone_sec   = $signed(zone_hours) * $signed(13'd3600);
		zone_ext   = {{15{zone_sec[16]}}, zone_sec};
		day_prod   = 34'(days_p1_s2) * grmc_pkg::SEC_PER_DAY;
		base_sec   = day_prod[31:0] + grmc_pkg::EPOCH_LESS_DAY
			+ 32'(hour_s2) * grmc_pkg::SEC_PER_HOUR
			+ 32'(minute_s2) * grmc_pkg::SEC_PER_MIN
			+ 32'(second_s2) + zone_ext;
		recip_prod = 27'(total_ms_s2) * grmc_pkg::RECIP_MS;
	end

	// the estimate is the true quotient or one below it
	always_comb begin
		qk      = 17'(q_est_s3) * 17'(grmc_pkg::MS_PER_SEC);
		rem_est = 11'(total_ms_s3 - qk);
		if (rem_est >= 11'(grmc_pkg::MS_PER_SEC)) begin
			q_fix  = q_est_s3 + 7'd1;
			ms_fix = 10'(rem_est - 11'(grmc_pkg::MS_PER_SEC));
		end else begin
			q_fix  = q_est_s3;
			ms_fix = rem_est[9:0];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1 <= in_item;
		end
		if (adv_s2) begin
			mode_s2     <= item_s1.mode;
			days_p1_s2  <= days_p1;
			hour_s2     <= item_s1.fix_hour;
			minute_s2   <= item_s1.fix_minute;
			second_s2   <= item_s1.fix_second;
			total_ms_s2 <= total_ms;
		end
		if (adv_s3) begin
			mode_s3     <= mode_s2;
			base_sec_s3 <= base_sec;
			q_est_s3    <= recip_prod[grmc_pkg::RECIP_SHIFT+6:grmc_pkg::RECIP_SHIFT];
			total_ms_s3 <= total_ms_s2;
		end
		if (adv_s4) begin
			time_s4.mode    <= mode_s3;
			time_s4.gps_sec <= base_sec_s3 + 32'(q_fix);
			time_s4.gps_ms  <= ms_fix;
		end
	end

	assign out_valid = v_s4;
	assign out_time  = time_s4;

endmodule

// File: rtl/gps_resync_millisecond_clock_top.sv
// top level of the millisecond clock with GPS resynchronization
//
// Every slave beat is one item; tuser carries its kind: a one-millisecond
// tick, a GPS fix or a plain read. Each item gives exactly one master beat
// with the local Unix seconds and milliseconds after the item and a flag
// that is set when a fix replaced the local time. A fix replaces the time
// when sync is enabled and the seconds differ by more than the threshold.
// Registers are written on the cfg channel (index, data), always ready.
// From slave beat to master beat an item passes an input register, three
// stages of calendar and millisecond split math, and the state stage
// that updates the clock and loads the master output register.
// Throughput is one item per cycle while the receiver takes every beat, so
// a tick can follow a fix directly. When the receiver stalls the stages
// keep filling, and slave tready drops only once every stage holds a beat.
// Reset clears the clock to zero, sync enable to 1, zone to 0 and the
// threshold to 2, and empties the pipeline.
module gps_resync_millisecond_clock_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// fix_year, fix_month, fix_day, fix_hour, fix_minute, fix_second,
	// fix_centi, fix_age_ms, zero fill
	input  logic [63:0] s_axis_tdata,
	// mode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// unix_seconds, milliseconds, synced, zero fill
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic        sync_enable_q;
	logic [4:0]  zone_hours_q;
	logic [15:0] resync_thresh_q;

	// clock state and output register
	logic [31:0] seconds_now_q;
	logic [9:0]  millis_now_q;
	logic        out_valid_q;
	logic [31:0] out_sec_q;
	logic [9:0]  out_ms_q;
	logic        out_synced_q;

	grmc_pkg::fix_item_t in_item;
	grmc_pkg::fix_time_t fix_time;
	logic                fix_valid;
	logic                fix_ready;
	logic                fix_take;

	logic [31:0] next_sec;
	logic [9:0]  next_ms;
	logic        next_synced;
	logic [31:0] diff;

	// unpack the slave beat
	assign in_item.mode       = s_axis_tuser;
	assign in_item.fix_year   = s_axis_tdata[11:0];
	assign in_item.fix_month  = s_axis_tdata[15:12];
	assign in_item.fix_day    = s_axis_tdata[20:16];
	assign in_item.fix_hour   = s_axis_tdata[25:21];
	assign in_item.fix_minute = s_axis_tdata[31:26];
	assign in_item.fix_second = s_axis_tdata[37:32];
	assign in_item.fix_centi  = s_axis_tdata[44:38];
	assign in_item.fix_age_ms = s_axis_tdata[60:45];

	grmc_fix_pipe u_fix_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.zone_hours (zone_hours_q),
		.out_valid  (fix_valid),
		.out_ready  (fix_ready),
		.out_time   (fix_time)
	);

	assign fix_ready = !out_valid_q || m_axis_tready;
	assign fix_take  = fix_valid && fix_ready;
	assign cfg_ready = 1'b1;

	// next clock value for the item in the state stage
	always_comb begin
		next_sec    = seconds_now_q;
		next_ms     = millis_now_q;
		next_synced = 1'b0;
		diff        = (fix_time.gps_sec > seconds_now_q) ?
			(fix_time.gps_sec - seconds_now_q) : (seconds_now_q - fix_time.gps_sec);
		case (fix_time.mode)
			grmc_pkg::MODE_TICK: begin
				if (millis_now_q >= grmc_pkg::MS_MAX) begin
					next_ms  = 10'd0;
					next_sec = seconds_now_q + 32'd1;
				end else begin
					next_ms = millis_now_q + 10'd1;
				end
			end
			grmc_pkg::MODE_FIX: begin
				if (sync_enable_q && (diff > 32'(resync_thresh_q))) begin
					next_sec    = fix_time.gps_sec;
					next_ms     = fix_time.gps_ms;
					next_synced = 1'b1;
				end
			end
			default: begin
				next_sec = seconds_now_q;
			end
		endcase
	end

	// configuration writes, clock state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_enable_q   <= grmc_pkg::SYNC_ENABLE_RST;
			zone_hours_q    <= grmc_pkg::ZONE_HOURS_RST;
			resync_thresh_q <= grmc_pkg::RESYNC_THRESH_RST;
			seconds_now_q   <= 32'd0;
			millis_now_q    <= 10'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					grmc_pkg::REG_SYNC_ENABLE:   sync_enable_q   <= cfg_data[0];
					grmc_pkg::REG_ZONE_HOURS:    zone_hours_q    <= cfg_data[4:0];
					grmc_pkg::REG_RESYNC_THRESH: resync_thresh_q <= cfg_data;
					default: begin
						sync_enable_q <= sync_enable_q;
					end
				endcase
			end
			if (fix_take) begin
				seconds_now_q <= next_sec;
				millis_now_q  <= next_ms;
			end
			if (fix_ready) begin
				out_valid_q <= fix_valid;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (fix_take) begin
			out_sec_q    <= next_sec;
			out_ms_q     <= next_ms;
			out_synced_q <= next_synced;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_synced_q, out_ms_q, out_sec_q};

endmodule

// File: test/grmc_checker.sv
// checker for the GPS resync millisecond clock: tracks the clock state and compares result beats
module grmc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// fix_year, fix_month, fix_day, fix_hour, fix_minute, fix_second,
	// fix_centi, fix_age_ms, zero fill
	input  logic [63:0] s_axis_tdata,
	// mode
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// unix_seconds, milliseconds, synced, zero fill
	input  logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          awaiting,
	output int          resyncs
);

	localparam logic [31:0] UNIX_AT_2000 = 32'd946684800;
	localparam logic [31:0] SEC_MS       = 32'd1000;
	localparam logic [31:0] HOUR_SEC     = 32'd3600;
	localparam logic [31:0] CENTI_MS     = 32'd10;

	typedef struct packed {
		logic [31:0] secs;
		logic [9:0]  ms;
		logic        synced;
	} clock_beat_t;

	// local clock and register copies
	logic [31:0] now_sec;
	logic [9:0]  now_ms;
	logic        sync_on;
	logic [4:0]  zone_hours;
	logic [15:0] thresh;

	clock_beat_t owed[$];

	// days in month m of a common year
	function automatic logic [31:0] month_length(input logic [31:0] m);
		logic [31:0] len;
		case (m)
			32'd2:                      len = 32'd28;
			32'd4, 32'd6, 32'd9, 32'd11: len = 32'd30;
			default:                    len = 32'd31;
		endcase
		return len;
	endfunction

	// calendar fields to unix seconds, leap day every fourth year, all mod 2^32
	function automatic logic [31:0] calendar_seconds(input logic [11:0] year,
		input logic [3:0] month, input logic [4:0] day, input logic [4:0] hour,
		input logic [5:0] minute, input logic [5:0] second);
		logic [31:0] yrs;
		logic [31:0] mon;
		logic [31:0] days;
		logic [31:0] i;
		yrs = (year >= 12'd2000) ? {20'd0, year} - 32'd2000 : {20'd0, year};
		yrs = yrs & 32'hFF;
		mon = {28'd0, month};
		if (mon < 32'd1)
			mon = 32'd1;
		if (mon > 32'd12)
			mon = 32'd12;
		days = {27'd0, day};
		for (i = 32'd1; i < mon; i++)
			days = days + month_length(i);
		if (mon > 32'd2 && yrs[1:0] == 2'b00)
			days = days + 32'd1;
		days = days + 32'd365 * yrs + (yrs + 32'd3) / 32'd4 - 32'd1;
		return UNIX_AT_2000 + ((days * 32'd24 + {27'd0, hour}) * 32'd60
			+ {26'd0, minute}) * 32'd60 + {26'd0, second};
	endfunction

	// advance the clock copy by one input beat and queue the result it owes
	task automatic predict_beat(input logic [1:0] kind, input logic [63:0] word);
		logic [31:0] ms_total;
		logic [31:0] zone_ext;
		logic [31:0] fix_sec;
		logic [31:0] delta;
		logic [9:0]  fix_ms;
		clock_beat_t res;
		res.synced = 1'b0;
		case (kind)
			grmc_pkg::MODE_TICK: begin
				if (now_ms >= 10'd999) begin
					now_ms = 10'd0;
					now_sec = now_sec + 32'd1;
				end else begin
					now_ms = now_ms + 10'd1;
				end
			end
			grmc_pkg::MODE_FIX: begin
				ms_total = {25'd0, word[44:38]} * CENTI_MS + {16'd0, word[60:45]};
				zone_ext = {{27{zone_hours[4]}}, zone_hours};
				fix_sec = calendar_seconds(word[11:0], word[15:12], word[20:16],
					word[25:21], word[31:26], word[37:32])
					+ ms_total / SEC_MS + zone_ext * HOUR_SEC;
				fix_ms = 10'(ms_total % SEC_MS);
				// plain absolute distance, no modular wrap
				delta = (fix_sec > now_sec) ? fix_sec - now_sec : now_sec - fix_sec;
				if (sync_on && delta > {16'd0, thresh}) begin
					now_sec = fix_sec;
					now_ms = fix_ms;
					res.synced = 1'b1;
					resyncs++;
				end
			end
			// reads and the spare code leave the clock alone
			default: ;
		endcase
		res.secs = now_sec;
		res.ms = now_ms;
		owed.push_back(res);
	endtask

	// compare one result beat with the oldest owed result
	task automatic check_beat(input logic [47:0] word);
		clock_beat_t want;
		if (owed.size() == 0) begin
			$error("result beat with nothing owed: unix_seconds %0d milliseconds %0d",
				word[31:0], word[41:32]);
			errors++;
		end else begin
			want = owed.pop_front();
			if (word[31:0] !== want.secs) begin
				$error("unix_seconds expected %0d actual %0d", want.secs, word[31:0]);
				errors++;
			end
			if (word[41:32] !== want.ms) begin
				$error("milliseconds expected %0d actual %0d", want.ms, word[41:32]);
				errors++;
			end
			if (word[42] !== want.synced) begin
				$error("synced expected %0d actual %0d", want.synced, word[42]);
				errors++;
			end
		end
	endtask

	initial begin
		errors = 0;
		resyncs = 0;
		awaiting = 0;
	end

	// watch all three channels
	always @(posedge clk) begin
		if (!arst_n) begin
			now_sec = 32'd0;
			now_ms = 10'd0;
			sync_on = grmc_pkg::SYNC_ENABLE_RST;
			zone_hours = grmc_pkg::ZONE_HOURS_RST;
			thresh = grmc_pkg::RESYNC_THRESH_RST;
			owed.delete();
			awaiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					grmc_pkg::REG_SYNC_ENABLE:   sync_on = cfg_data[0];
					grmc_pkg::REG_ZONE_HOURS:    zone_hours = cfg_data[4:0];
					grmc_pkg::REG_RESYNC_THRESH: thresh = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				check_beat(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				predict_beat(s_axis_tuser, s_axis_tdata);
			awaiting <= owed.size();
		end
	end

endmodule

// File: test/tb_gps_resync_millisecond_clock_top.sv
// testbench top for the GPS resync millisecond clock: stimulus, idling and verdict
module tb_gps_resync_millisecond_clock_top;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 80;
	localparam int SETTLE      = 12;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 150;
	localparam int MAX_GAP     = 18;

	// the unused mode code, which the block treats as a read
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// fix_year, fix_month, fix_day, fix_hour, fix_minute, fix_second,
	// fix_centi, fix_age_ms, zero fill
	logic [63:0] s_axis_tdata = 64'd0;
	// mode
	logic [1:0]  s_axis_tuser = grmc_pkg::MODE_READ;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// unix_seconds, milliseconds, synced, zero fill
	logic [47:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = grmc_pkg::REG_SYNC_ENABLE;
	logic [15:0] cfg_data = 16'd0;

	int errors;
	int awaiting;
	int resyncs;

	int cycle_count = 0;
	int n_ticks = 0;
	int n_fixes = 0;
	int n_reads = 0;
	int n_settings = 0;

	// idling controls for the sender and the receiver
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	logic hold_req = 1'b0;

	// last valid fix date, used to make fixes close to the local time
	logic [11:0] base_year = 12'd2024;
	logic [3:0]  base_month = 4'd6;
	logic [4:0]  base_day = 5'd15;
	logic [4:0]  base_hour = 5'd12;
	logic [5:0]  base_minute = 6'd30;
	logic [5:0]  base_second = 6'd30;

	gps_resync_millisecond_clock_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	grmc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.awaiting     (awaiting),
		.resyncs      (resyncs)
	);

	always #(CLK_HALF) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random backpressure per beat, one long hold on request
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				gap = LONG_HOLD;
				hold_req = 1'b0;
			end else if (rx_quiet) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, MAX_GAP);
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// pack fix fields into a slave tdata word
	function automatic logic [63:0] fix_word(input logic [11:0] year, input logic [3:0] month,
		input logic [4:0] day, input logic [4:0] hour, input logic [5:0] minute,
		input logic [5:0] second, input logic [6:0] centi, input logic [15:0] age);
		return {3'b000, age, centi, second, minute, hour, day, month, year};
	endfunction

	// random content for beats whose fix fields are ignored
	function automatic logic [63:0] noise_word();
		return {3'b000, 29'($urandom), $urandom};
	endfunction

	// send one slave beat after a random gap, or at once when the sender is quiet
	task automatic offer(input logic [1:0] kind, input logic [63:0] word);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tuser <= kind;
		s_axis_tdata <= word;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		case (kind)
			grmc_pkg::MODE_TICK: n_ticks++;
			grmc_pkg::MODE_FIX:  n_fixes++;
			default:             n_reads++;
		endcase
	endtask

	// stop sending until every owed result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
	endtask

	// write all three registers, unused data bits random
	task automatic set_config(input logic en, input logic [4:0] zone, input logic [15:0] thr);
		write_reg(grmc_pkg::REG_SYNC_ENABLE, {15'($urandom), en});
		write_reg(grmc_pkg::REG_ZONE_HOURS, {11'($urandom), zone});
		write_reg(grmc_pkg::REG_RESYNC_THRESH, thr);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// fix beat: mostly near the last date, sometimes a fresh date or raw bits
	task automatic make_fix(output logic [63:0] word);
		int pick;
		logic [5:0]  sec;
		logic [15:0] age;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			word = noise_word();
		end else begin
			if (pick < 32) begin
				base_year = 12'(2000 + $urandom_range(0, 99));
				base_month = 4'($urandom_range(1, 12));
				base_day = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31))
					: 5'($urandom_range(1, 28));
				base_hour = 5'($urandom_range(0, 23));
				base_minute = 6'($urandom_range(0, 59));
				base_second = 6'($urandom_range(4, 55));
			end
			sec = base_second + 6'($urandom_range(0, 8)) - 6'd4;
			age = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
			word = fix_word(base_year, base_month, base_day, base_hour, base_minute, sec,
				7'($urandom_range(0, 99)), age);
		end
	endtask

	task automatic random_item();
		int pick;
		logic [63:0] word;
		pick = $urandom_range(0, 99);
		if (pick < 68) begin
			offer(grmc_pkg::MODE_TICK, noise_word());
		end else if (pick < 78) begin
			offer(grmc_pkg::MODE_READ, noise_word());
		end else if (pick < 81) begin
			offer(MODE_SPARE, noise_word());
		end else begin
			make_fix(word);
			offer(grmc_pkg::MODE_FIX, word);
		end
	endtask

	// directed beats under the reset settings
	task automatic directed_items();
		offer(grmc_pkg::MODE_READ, 64'd0);
		offer(grmc_pkg::MODE_TICK, {3'b000, {61{1'b1}}});
		offer(MODE_SPARE, 64'd0);
		// first fix always replaces the zero clock
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 16'd0));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 16'd0));
		// difference equal to the threshold, then one above it
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd2, 7'd0, 16'd0));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd3, 7'd0, 16'd0));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 7'd99, 16'hFFFF));
		offer(grmc_pkg::MODE_TICK, 64'd0);
		// leap year, before and after the leap day
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2004, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 7'd0, 16'd0));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2004, 4'd3, 5'd1, 5'd12, 6'd0, 6'd0, 7'd0, 16'd0));
		// out of range month, day, hour, minute, second and centiseconds
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2024, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63, 7'd127, 16'd0));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2023, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0, 7'd0, 16'd0));
		// years outside 2000..2099
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd1999, 4'd2, 5'd29, 5'd1, 6'd2, 6'd3, 7'd4, 16'd5));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd0, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 7'd0, 16'd0));
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'hFFF, 4'd13, 5'd31, 5'd23, 6'd0, 6'd0, 7'd0, 16'd0));
		// land on the last second with 999 ms, then tick across the wrap
		offer(grmc_pkg::MODE_FIX,
			fix_word(12'd2106, 4'd2, 5'd6, 5'd6, 6'd28, 6'd15, 7'd99, 16'd9));
		offer(grmc_pkg::MODE_TICK, 64'd0);
		offer(grmc_pkg::MODE_READ, 64'd0);
		offer(grmc_pkg::MODE_TICK, 64'd0);
	endtask

	// main sequence
	initial begin : stimulus
		int phase;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		directed_items();
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			case (phase)
				0: set_config(1'b1, 5'b10100, 16'd0);
				1: begin
					set_config(1'b1, 5'd14, 16'hFFFF);
					// sender keeps pushing while the receiver holds off
					tx_quiet = 1'b1;
					hold_req = 1'b1;
				end
				2: set_config(1'b0, 5'($urandom), 16'd2);
				3: set_config(1'b1, 5'b10000, 16'd1);
				4: set_config(1'b1, 5'd15, 16'd2);
				default: set_config($urandom_range(0, 4) != 0, 5'($urandom),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end
		drain();
		$display("covered %0d ticks, %0d gps fixes (%0d replaced the clock), %0d reads",
			n_ticks, n_fixes, resyncs, n_reads);
		$display("across %0d register settings, with random gaps and one long output hold",
			n_settings);
		if (errors == 0 && awaiting == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
